// ----- sv/msp_pkg.sv -----
// Shared types, constants and lookup functions for the mode pulse sequencer.
`default_nettype none

package msp_pkg;

  // Fixed register widths
  localparam int TICK_W    = 16;
  localparam int BOUND_W   = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BANDS = 4;
  localparam int SEG_W     = 7;
  localparam int PINS_W    = 4;
  localparam int MODE_W    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_ONE_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_TWO_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_THREE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDARY_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_PERIOD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOWER        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_UPPER        = 3'd7;

  // Register reset values
  localparam logic [TICK_W-1:0] RST_MODE_ONE_TICKS    = 16'd100;
  localparam logic [TICK_W-1:0] RST_MODE_TWO_TICKS    = 16'd200;
  localparam logic [TICK_W-1:0] RST_MODE_THREE_TICKS  = 16'd300;
  localparam logic [TICK_W-1:0] RST_SECONDARY_TICKS   = 16'd100;
  localparam logic [TICK_W-1:0] RST_SHORT_PRESS_LIMIT = 16'd50;
  localparam logic [TICK_W-1:0] RST_BATTERY_PERIOD    = 16'd1000;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_ONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TWO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_THREE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Display and LED patterns
  localparam logic [SEG_W-1:0]  SEG_MODE_ONE   = 7'd48;
  localparam logic [SEG_W-1:0]  SEG_MODE_TWO   = 7'd109;
  localparam logic [SEG_W-1:0]  SEG_MODE_THREE = 7'd121;
  localparam logic [SEG_W-1:0]  SEG_BLANK      = 7'd0;
  localparam logic [PINS_W-1:0] PINS_ALL_ON    = 4'd15;

  typedef struct packed {
    logic [TICK_W-1:0] mode_one_ticks;
    logic [TICK_W-1:0] mode_two_ticks;
    logic [TICK_W-1:0] mode_three_ticks;
    logic [TICK_W-1:0] secondary_ticks;
    logic [TICK_W-1:0] short_press_limit;
  } pulse_cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0]  battery_period;
    logic [BOUND_W-1:0] band_lower;
    logic [BOUND_W-1:0] band_upper;
  } gauge_cfg_t;

  typedef struct packed {
    logic              main_drive;
    logic              secondary_drive;
    logic [SEG_W-1:0]  segment_pattern;
    logic [MODE_W-1:0] current_mode;
  } pulse_res_t;

  typedef struct packed {
    logic [PINS_W-1:0] battery_pins;
    logic              sample_taken;
  } gauge_res_t;

  // Segment pattern for a mode; out-of-range codes show mode three
  function automatic logic [SEG_W-1:0] seg_code(input logic [MODE_W-1:0] mode);
    logic [SEG_W-1:0] code;
    unique case (mode)
      MODE_ONE: code = SEG_MODE_ONE;
      MODE_TWO: code = SEG_MODE_TWO;
      default:  code = SEG_MODE_THREE;
    endcase
    return code;
  endfunction

  // LED pins for a battery band, band one first
  function automatic logic [PINS_W-1:0] band_pins(input logic [1:0] band);
    logic [PINS_W-1:0] pins;
    unique case (band)
      2'd0:    pins = 4'd7;
      2'd1:    pins = 4'd3;
      2'd2:    pins = 4'd1;
      default: pins = 4'd0;
    endcase
    return pins;
  endfunction

endpackage

`default_nettype wire

// ----- sv/msp_pulse.sv -----
// Mode selector, press counter, main and secondary pulse timers, segment display.
`default_nettype none

module msp_pulse
  import msp_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         step_en,
  input  wire         pressed,
  input  wire         advance,
  input  pulse_cfg_t  cfg,
  output pulse_res_t  res_nxt
);

  localparam int CW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;

  logic [TIMER_WIDTH-1:0] press_cnt_r, press_cnt_nxt;
  logic [TIMER_WIDTH-1:0] main_el_r, main_el_nxt;
  logic [TIMER_WIDTH-1:0] sec_el_r, sec_el_nxt;
  logic                   run_r, run_nxt;
  logic                   sec_r, sec_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [MODE_W-1:0]      shown_r, shown_nxt;
  logic                   main_pin_r, main_pin_nxt;
  logic                   sec_pin_r, sec_pin_nxt;
  logic [SEG_W-1:0]       seg_r, seg_nxt;
  logic [TICK_W-1:0]      main_len;

  // Main pulse length for the mode in force after this tick's advance
  always_comb begin
    unique case (mode_nxt)
      MODE_ONE: main_len = cfg.mode_one_ticks;
      MODE_TWO: main_len = cfg.mode_two_ticks;
      default:  main_len = cfg.mode_three_ticks;
    endcase
  end

  // One tick: mode advance, display, then button and timers
  always_comb begin
    mode_nxt     = mode_r;
    shown_nxt    = shown_r;
    seg_nxt      = seg_r;
    press_cnt_nxt = press_cnt_r;
    run_nxt      = run_r;
    sec_nxt      = sec_r;
    main_el_nxt  = main_el_r;
    sec_el_nxt   = sec_el_r;
    main_pin_nxt = main_pin_r;
    sec_pin_nxt  = sec_pin_r;

    if (advance && !run_r && !sec_r) begin
      mode_nxt = (mode_r >= MODE_THREE) ? MODE_ONE : mode_r + 2'd1;
    end

    if (shown_r != mode_nxt) begin
      shown_nxt = mode_nxt;
      seg_nxt   = seg_code(mode_nxt);
    end

    if (pressed) begin
      // saturating hold counter
      if (press_cnt_r != {TIMER_WIDTH{1'b1}}) begin
        press_cnt_nxt = press_cnt_r + TIMER_WIDTH'(1);
      end
    end else begin
      // short press starts a run
      if ((press_cnt_r != '0) && (CW'(press_cnt_r) < CW'(cfg.short_press_limit)) &&
          !sec_r && !run_r) begin
        run_nxt = 1'b1;
      end
      // main pulse; its end hands over to the secondary pulse
      if (run_nxt && !sec_nxt) begin
        if (main_el_r == '0) begin
          main_pin_nxt = 1'b1;
        end
        main_el_nxt = main_el_r + TIMER_WIDTH'(1);
        if (CW'(main_el_nxt) >= CW'(main_len)) begin
          main_pin_nxt = 1'b0;
          main_el_nxt  = '0;
          sec_nxt      = 1'b1;
          run_nxt      = 1'b0;
        end
      end
      // secondary pulse, ends on exact match (wraps otherwise)
      if (sec_nxt && !run_nxt) begin
        if (sec_el_r == '0) begin
          sec_pin_nxt = 1'b1;
        end
        sec_el_nxt = sec_el_r + TIMER_WIDTH'(1);
        if (CW'(sec_el_nxt) == CW'(cfg.secondary_ticks)) begin
          sec_pin_nxt = 1'b0;
          sec_nxt     = 1'b0;
          sec_el_nxt  = '0;
        end
      end
      press_cnt_nxt = '0;
    end
  end

  // State update once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r <= '0;
      main_el_r   <= '0;
      sec_el_r    <= '0;
      run_r       <= 1'b0;
      sec_r       <= 1'b0;
      mode_r      <= MODE_ONE;
      shown_r     <= MODE_NONE;
      main_pin_r  <= 1'b0;
      sec_pin_r   <= 1'b0;
      seg_r       <= SEG_BLANK;
    end else if (step_en) begin
      press_cnt_r <= press_cnt_nxt;
      main_el_r   <= main_el_nxt;
      sec_el_r    <= sec_el_nxt;
      run_r       <= run_nxt;
      sec_r       <= sec_nxt;
      mode_r      <= mode_nxt;
      shown_r     <= shown_nxt;
      main_pin_r  <= main_pin_nxt;
      sec_pin_r   <= sec_pin_nxt;
      seg_r       <= seg_nxt;
    end
  end

  assign res_nxt.main_drive      = main_pin_nxt;
  assign res_nxt.secondary_drive = sec_pin_nxt;
  assign res_nxt.segment_pattern = seg_nxt;
  assign res_nxt.current_mode    = mode_nxt;

endmodule

`default_nettype wire

// ----- sv/msp_gauge.sv -----
// Battery sample timer, band classifier and battery LED register.
`default_nettype none

module msp_gauge
  import msp_pkg::*;
#(
  parameter int TIMER_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    step_en,
  input  wire [SAMPLE_WIDTH-1:0] sample,
  input  gauge_cfg_t             cfg,
  output gauge_res_t             res_nxt
);

  localparam int CW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;
  localparam int BW = BOUND_W + NUM_BANDS * SAMPLE_WIDTH;

  logic [TIMER_WIDTH-1:0]  timer_r, timer_nxt;
  logic [SAMPLE_WIDTH-1:0] last_r, last_nxt;
  logic [PINS_W-1:0]       pins_r, pins_nxt;
  logic                    taken;
  logic [BW-1:0]           lo_ext, hi_ext;
  logic [NUM_BANDS-1:0]    in_band;

  assign lo_ext = BW'(cfg.band_lower);
  assign hi_ext = BW'(cfg.band_upper);

  // Per-band range compare, exclusive low and inclusive high
  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      in_band[b] = (sample > lo_ext[b*SAMPLE_WIDTH +: SAMPLE_WIDTH]) &&
                   (sample <= hi_ext[b*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
    end
  end

  assign taken = (CW'(timer_r) == CW'(cfg.battery_period));

  // Sampling tick, lowest matching band wins, then timer countdown
  always_comb begin
    pins_nxt = pins_r;
    last_nxt = last_r;
    if (taken) begin
      if (sample != last_r) begin
        priority if (in_band[0]) pins_nxt = band_pins(2'd0);
        else if (in_band[1])     pins_nxt = band_pins(2'd1);
        else if (in_band[2])     pins_nxt = band_pins(2'd2);
        else if (in_band[3])     pins_nxt = band_pins(2'd3);
        else                     pins_nxt = pins_r;
      end
      last_nxt = sample;
    end
    if (timer_r != '0) begin
      timer_nxt = timer_r - TIMER_WIDTH'(1);
    end else begin
      timer_nxt = TIMER_WIDTH'(cfg.battery_period);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= TIMER_WIDTH'(RST_BATTERY_PERIOD);
      last_r  <= '0;
      pins_r  <= PINS_ALL_ON;
    end else if (step_en) begin
      timer_r <= timer_nxt;
      last_r  <= last_nxt;
      pins_r  <= pins_nxt;
    end
  end

  assign res_nxt.battery_pins = pins_nxt;
  assign res_nxt.sample_taken = taken;

endmodule

`default_nettype wire

// ----- sv/mode_pulse_sequencer_with_battery_gauge.sv -----
// Top level: config registers, input register, pulse and gauge units, result register.
//
// Each input item is one tick: button level, mode advance request and a
// battery ADC sample. Each item yields exactly one result item with the
// pin levels, segment pattern, battery LED pattern and mode after that tick.
// Channels: in_* and out_* use valid/ready; an item moves when both are high.
// The cfg_* port writes one register per cycle with cfg_wr_en; write only
// while no item is in flight.
// An accepted item passes the input register, then the result register,
// where its result is offered. Throughput: one item per cycle while
// out_ready stays high, set by the combinational tick update in between.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// pulse state, blanks the display and drives all battery pins high.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; in_ready drops only when both are
// full and out_ready is low.
`default_nettype none

module mode_pulse_sequencer_with_battery_gauge
  import msp_pkg::*;
#(
  parameter int TIMER_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input channel
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_button_pressed,
  input  wire                    in_mode_advance,
  input  wire [SAMPLE_WIDTH-1:0] in_battery_sample,
  // result channel
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_main_drive,
  output logic                   out_secondary_drive,
  output logic [SEG_W-1:0]       out_segment_pattern,
  output logic [PINS_W-1:0]      out_battery_pins,
  output logic [MODE_W-1:0]      out_current_mode,
  output logic                   out_sample_taken,
  // configuration port
  input  wire                    cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_W-1:0]        cfg_wr_data
);

  pulse_cfg_t              pcfg_r;
  gauge_cfg_t              gcfg_r;
  logic                    in_v_r;
  logic                    pressed_r;
  logic                    advance_r;
  logic [SAMPLE_WIDTH-1:0] sample_r;
  logic                    out_v_r;
  pulse_res_t              pres_r, pres_nxt;
  gauge_res_t              gres_r, gres_nxt;
  logic                    step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcfg_r.mode_one_ticks    <= RST_MODE_ONE_TICKS;
      pcfg_r.mode_two_ticks    <= RST_MODE_TWO_TICKS;
      pcfg_r.mode_three_ticks  <= RST_MODE_THREE_TICKS;
      pcfg_r.secondary_ticks   <= RST_SECONDARY_TICKS;
      pcfg_r.short_press_limit <= RST_SHORT_PRESS_LIMIT;
      gcfg_r.battery_period    <= RST_BATTERY_PERIOD;
      gcfg_r.band_lower        <= '0;
      gcfg_r.band_upper        <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE_ONE_TICKS:    pcfg_r.mode_one_ticks    <= cfg_wr_data[TICK_W-1:0];
        REG_MODE_TWO_TICKS:    pcfg_r.mode_two_ticks    <= cfg_wr_data[TICK_W-1:0];
        REG_MODE_THREE_TICKS:  pcfg_r.mode_three_ticks  <= cfg_wr_data[TICK_W-1:0];
        REG_SECONDARY_TICKS:   pcfg_r.secondary_ticks   <= cfg_wr_data[TICK_W-1:0];
        REG_SHORT_PRESS_LIMIT: pcfg_r.short_press_limit <= cfg_wr_data[TICK_W-1:0];
        REG_BATTERY_PERIOD:    gcfg_r.battery_period    <= cfg_wr_data[TICK_W-1:0];
        REG_BAND_LOWER:        gcfg_r.band_lower        <= cfg_wr_data[BOUND_W-1:0];
        REG_BAND_UPPER:        gcfg_r.band_upper        <= cfg_wr_data[BOUND_W-1:0];
        default:               ;
      endcase
    end
  end

  // Handshake: tick is processed when the result register can take it
  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pressed_r <= in_button_pressed;
      advance_r <= in_mode_advance;
      sample_r  <= in_battery_sample;
    end
  end

  msp_pulse #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_pulse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .pressed (pressed_r),
    .advance (advance_r),
    .cfg     (pcfg_r),
    .res_nxt (pres_nxt)
  );

  msp_gauge #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_gauge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .sample  (sample_r),
    .cfg     (gcfg_r),
    .res_nxt (gres_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pres_r <= pres_nxt;
      gres_r <= gres_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_main_drive      = pres_r.main_drive;
  assign out_secondary_drive = pres_r.secondary_drive;
  assign out_segment_pattern = pres_r.segment_pattern;
  assign out_current_mode    = pres_r.current_mode;
  assign out_battery_pins    = gres_r.battery_pins;
  assign out_sample_taken    = gres_r.sample_taken;

  // Main and secondary pulses never overlap
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(pres_r.main_drive && pres_r.secondary_drive))
    else $error("main and secondary drive both high");

  // Mode stays within the three valid modes
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (pres_r.current_mode != MODE_NONE))
    else $error("current mode out of range");

  // Input stalls only when the input register holds an unprocessed item
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && out_v_r && !out_ready))
    else $error("input stalled without cause");

  // A processed tick always lands in the result register
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed tick produced no result");

endmodule

`default_nettype wire

// ----- sim/mode_pulse_sequencer_with_battery_gauge_tb.sv -----
// Testbench for the mode pulse sequencer with battery gauge: directed and random ticks vs. a predictor.
`timescale 1ns / 1ps

module mode_pulse_sequencer_with_battery_gauge_tb;
  import msp_pkg::*;

  localparam int SMP_W        = 12;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic             pressed;
    logic             advance;
    logic [SMP_W-1:0] sample;
  } tick_t;

  typedef struct packed {
    logic              main_drive;
    logic              secondary_drive;
    logic [SEG_W-1:0]  segment_pattern;
    logic [PINS_W-1:0] battery_pins;
    logic [MODE_W-1:0] current_mode;
    logic              sample_taken;
  } pins_t;

  typedef struct packed {
    logic [TICK_W-1:0]  len_one, len_two, len_three, tail_len, press_lim, period;
    logic [BOUND_W-1:0] lo, hi;
  } setup_t;

  // DUT signals, all inputs known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_button_pressed = 1'b0;
  logic              in_mode_advance = 1'b0;
  logic [SMP_W-1:0]  in_battery_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_main_drive;
  logic              out_secondary_drive;
  logic [SEG_W-1:0]  out_segment_pattern;
  logic [PINS_W-1:0] out_battery_pins;
  logic [MODE_W-1:0] out_current_mode;
  logic              out_sample_taken;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  // predictor copy of the registers
  logic [TICK_W-1:0]  mode_len [0:2];
  logic [TICK_W-1:0]  tail_len, press_lim, adc_period;
  logic [BOUND_W-1:0] band_lo, band_hi;

  // predictor copy of the state
  logic [TICK_W-1:0] presses, main_cnt, tail_cnt, adc_timer;
  logic [SMP_W-1:0]  prev_adc;
  logic              main_on, tail_on, main_pin, tail_pin;
  logic [MODE_W-1:0] cur_mode, shown;
  logic [SEG_W-1:0]  seg;
  logic [PINS_W-1:0] leds;

  pins_t             pending[$];
  pins_t             want;
  logic [SMP_W-1:0]  last_drawn = '0;
  logic              gaps_on = 1'b1;
  logic              stall_req = 1'b0;
  logic              stall_ack = 1'b0;
  int                stall_left = 0;
  int                fail_count = 0;
  int                items_sent = 0;
  int                results_seen = 0;
  int                cycle_count = 0;

  mode_pulse_sequencer_with_battery_gauge uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_button_pressed   (in_button_pressed),
    .in_mode_advance     (in_mode_advance),
    .in_battery_sample   (in_battery_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_main_drive      (out_main_drive),
    .out_secondary_drive (out_secondary_drive),
    .out_segment_pattern (out_segment_pattern),
    .out_battery_pins    (out_battery_pins),
    .out_current_mode    (out_current_mode),
    .out_sample_taken    (out_sample_taken),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // registers and state as they are after reset
  task automatic init_model();
    mode_len[0] = RST_MODE_ONE_TICKS;
    mode_len[1] = RST_MODE_TWO_TICKS;
    mode_len[2] = RST_MODE_THREE_TICKS;
    tail_len    = RST_SECONDARY_TICKS;
    press_lim   = RST_SHORT_PRESS_LIMIT;
    adc_period  = RST_BATTERY_PERIOD;
    band_lo     = '0;
    band_hi     = '0;
    presses     = '0;
    main_cnt    = '0;
    tail_cnt    = '0;
    adc_timer   = RST_BATTERY_PERIOD;
    prev_adc    = '0;
    main_on     = 1'b0;
    tail_on     = 1'b0;
    main_pin    = 1'b0;
    tail_pin    = 1'b0;
    cur_mode    = MODE_ONE;
    shown       = MODE_NONE;
    seg         = SEG_BLANK;
    leds        = PINS_ALL_ON;
  endtask

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_MODE_ONE_TICKS:    mode_len[0] = data[TICK_W-1:0];
      REG_MODE_TWO_TICKS:    mode_len[1] = data[TICK_W-1:0];
      REG_MODE_THREE_TICKS:  mode_len[2] = data[TICK_W-1:0];
      REG_SECONDARY_TICKS:   tail_len    = data[TICK_W-1:0];
      REG_SHORT_PRESS_LIMIT: press_lim   = data[TICK_W-1:0];
      REG_BATTERY_PERIOD:    adc_period  = data[TICK_W-1:0];
      REG_BAND_LOWER:        band_lo     = data[BOUND_W-1:0];
      REG_BAND_UPPER:        band_hi     = data[BOUND_W-1:0];
      default: ;
    endcase
  endfunction

  // one tick of the block: mode, battery, display, then button and pulses
  function automatic pins_t tick_model(input tick_t t);
    pins_t            r;
    logic             taken;
    logic             hit;
    logic [SMP_W-1:0] lo, hi;
    taken = 1'b0;
    hit   = 1'b0;
    if (t.advance && !main_on && !tail_on)
      cur_mode = (cur_mode >= MODE_THREE) ? MODE_ONE : cur_mode + 2'd1;

    // battery: lowest matching band wins, no band keeps the pins
    if (adc_timer == adc_period) begin
      taken = 1'b1;
      if (t.sample != prev_adc) begin
        for (int b = 0; b < NUM_BANDS; b++) begin
          lo = band_lo[b*SMP_W +: SMP_W];
          hi = band_hi[b*SMP_W +: SMP_W];
          if (!hit && t.sample > lo && t.sample <= hi) begin
            hit  = 1'b1;
            leds = PINS_ALL_ON >> (b + 1);  // 7, 3, 1, 0
          end
        end
      end
      prev_adc = t.sample;
    end
    adc_timer = (adc_timer != 0) ? adc_timer - 1'b1 : adc_period;

    if (shown != cur_mode) begin
      shown = cur_mode;
      case (cur_mode)
        MODE_ONE: seg = SEG_MODE_ONE;
        MODE_TWO: seg = SEG_MODE_TWO;
        default:  seg = SEG_MODE_THREE;
      endcase
    end

    // timers only move on released ticks
    if (t.pressed) begin
      if (presses != '1) presses = presses + 1'b1;
    end else begin
      if (presses != 0 && presses < press_lim && !tail_on && !main_on) main_on = 1'b1;
      if (main_on && !tail_on) begin
        if (main_cnt == 0) main_pin = 1'b1;
        main_cnt = main_cnt + 1'b1;
        if (main_cnt >= mode_len[cur_mode]) begin
          main_pin = 1'b0;
          main_cnt = '0;
          tail_on  = 1'b1;
          main_on  = 1'b0;
        end
      end
      if (tail_on && !main_on) begin
        if (tail_cnt == 0) tail_pin = 1'b1;
        tail_cnt = tail_cnt + 1'b1;  // wraps at 16 bits
        if (tail_cnt == tail_len) begin
          tail_pin = 1'b0;
          tail_on  = 1'b0;
          tail_cnt = '0;
        end
      end
      presses = '0;
    end

    r.main_drive      = main_pin;
    r.secondary_drive = tail_pin;
    r.segment_pattern = seg;
    r.battery_pins    = leds;
    r.current_mode    = cur_mode;
    r.sample_taken    = taken;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int exp_val);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen, what, got,
               exp_val);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        report("result with no tick waiting", 0, 0);
      end else begin
        want = pending.pop_front();
        if (out_main_drive !== want.main_drive)
          report("main_drive", out_main_drive, want.main_drive);
        if (out_secondary_drive !== want.secondary_drive)
          report("secondary_drive", out_secondary_drive, want.secondary_drive);
        if (out_segment_pattern !== want.segment_pattern)
          report("segment_pattern", out_segment_pattern, want.segment_pattern);
        if (out_battery_pins !== want.battery_pins)
          report("battery_pins", out_battery_pins, want.battery_pins);
        if (out_current_mode !== want.current_mode)
          report("current_mode", out_current_mode, want.current_mode);
        if (out_sample_taken !== want.sample_taken)
          report("sample_taken", out_sample_taken, want.sample_taken);
      end
      results_seen++;
    end
  end

  // result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= STALL_CYCLES;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(99) < 29);
    end
  end

  // offer one item, predict it once it is taken
  task automatic send_tick(input logic pressed, input logic advance, input logic [SMP_W-1:0] sample);
    tick_t t;
    t.pressed = pressed;
    t.advance = advance;
    t.sample  = sample;
    if (gaps_on) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_button_pressed <= pressed;
    in_mode_advance   <= advance;
    in_battery_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(tick_model(t));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // 16-bit value with random upper bits that the block must drop
  function automatic logic [CFG_W-1:0] with_junk(input logic [TICK_W-1:0] v);
    return {$urandom(), v};
  endfunction

  task automatic load_settings(input setup_t s);
    put_reg(REG_MODE_ONE_TICKS, with_junk(s.len_one));
    put_reg(REG_MODE_TWO_TICKS, with_junk(s.len_two));
    put_reg(REG_MODE_THREE_TICKS, with_junk(s.len_three));
    put_reg(REG_SECONDARY_TICKS, with_junk(s.tail_len));
    put_reg(REG_SHORT_PRESS_LIMIT, with_junk(s.press_lim));
    put_reg(REG_BATTERY_PERIOD, with_junk(s.period));
    put_reg(REG_BAND_LOWER, s.lo);
    put_reg(REG_BAND_UPPER, s.hi);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] pulse_len();
    return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
  endfunction

  function automatic setup_t random_setup();
    setup_t           s;
    logic [SMP_W-1:0] lo, hi;
    s.len_one   = pulse_len();
    s.len_two   = pulse_len();
    s.len_three = pulse_len();
    s.tail_len  = 16'($urandom_range(1, 12));
    s.press_lim = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8));
    s.period    = ($urandom_range(4) == 0) ? 16'($urandom_range(10, 30))
                                           : 16'($urandom_range(0, 6));
    for (int b = 0; b < NUM_BANDS; b++) begin
      lo = 12'($urandom_range(0, 3500));
      hi = ($urandom_range(7) == 0) ? 12'($urandom_range(0, lo))
                                    : 12'(lo + $urandom_range(1, 4095 - lo));
      s.lo[b*SMP_W +: SMP_W] = lo;
      s.hi[b*SMP_W +: SMP_W] = hi;
    end
    return s;
  endfunction

  // ADC value: random, repeated, inside a band, at a bound or at the rails
  function automatic logic [SMP_W-1:0] pick_sample();
    logic [SMP_W-1:0] s, lo, hi;
    int               b;
    b  = int'($urandom_range(NUM_BANDS - 1));
    lo = band_lo[b*SMP_W +: SMP_W];
    hi = band_hi[b*SMP_W +: SMP_W];
    case ($urandom_range(9))
      0, 1, 2, 3: s = 12'($urandom_range(4095));
      4, 5:       s = last_drawn;
      6, 7:       s = (hi > lo) ? 12'($urandom_range(hi, lo + 1)) : 12'($urandom_range(4095));
      8:          s = $urandom_range(1) ? '1 : '0;
      default:    s = $urandom_range(1) ? lo : hi;
    endcase
    last_drawn = s;
    return s;
  endfunction

  // one button gesture with random content
  task automatic play_sequence();
    int                hold;
    logic [TICK_W-1:0] cap;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin  // short press, then let the pulses run
        cap  = (press_lim > 11) ? 16'd11 : press_lim;
        hold = (cap > 1) ? $urandom_range(1, cap - 1) : 1;
        repeat (hold) send_tick(1'b1, 1'b0, pick_sample());
        repeat ($urandom_range(1, 25))
          send_tick($urandom_range(7) == 0, $urandom_range(7) == 0, pick_sample());
      end
      5: begin  // long press
        hold = (press_lim <= 20) ? press_lim + $urandom_range(0, 2) : $urandom_range(20, 30);
        repeat (hold) send_tick(1'b1, 1'b0, pick_sample());
        send_tick(1'b0, 1'b0, pick_sample());
      end
      6, 7: begin  // mode changes on released ticks
        repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'($urandom_range(1)), pick_sample());
      end
      default: begin  // noise
        repeat ($urandom_range(1, 5))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pick_sample());
      end
    endcase
  endtask

  // released ticks until no pulse runs
  task automatic settle();
    while (main_on || tail_on) send_tick(1'b0, 1'b0, pick_sample());
  endtask

  // reset values: display turns to mode one, all LEDs on, first tick samples
  task automatic test_defaults();
    gaps_on = 1'b0;
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd77);
    drain();
  endtask

  // pulse lengths one and zero, frozen timers, long press, mode wrap
  task automatic test_pulses_and_modes();
    setup_t s;
    s = random_setup();
    s.len_one   = 16'd1;
    s.len_two   = 16'd0;
    s.len_three = 16'd3;
    s.tail_len  = 16'd2;
    s.press_lim = 16'd3;
    s.period    = 16'd0;
    load_settings(s);
    gaps_on = 1'b1;
    send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());  // one-tick main pulse never shows
    send_tick(1'b0, 1'b1, pick_sample());  // advance ignored while running
    send_tick(1'b0, 1'b1, pick_sample());  // mode two
    send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());  // zero-length main pulse
    send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());  // short press during secondary: no run
    repeat (3) send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());  // press at the limit: no run
    send_tick(1'b0, 1'b1, pick_sample());  // mode three
    repeat (2) send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());
    send_tick(1'b0, 1'b1, pick_sample());
    send_tick(1'b1, 1'b0, pick_sample());  // held button freezes the timer
    send_tick(1'b0, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());
    send_tick(1'b0, 1'b1, pick_sample());  // wrap back to mode one
    drain();
  endtask

  // result side holds off while items keep coming
  task automatic test_backpressure();
    int goal;
    gaps_on = 1'b0;
    stall_req <= !stall_req;
    goal = items_sent + 120;
    while (items_sent < goal) play_sequence();
    drain();
  endtask

  task automatic test_random_ticks();
    int goal;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      drain();
      load_settings(random_setup());
      gaps_on = (ph != 2);
      goal = items_sent + 150;
      while (items_sent < goal) play_sequence();
    end
    settle();
    drain();
  endtask

  // band edges, overlap, no band, repeated sample
  task automatic test_battery_bands();
    setup_t s;
    s = random_setup();
    s.period = 16'd0;
    s.lo = {12'd0, 12'd1000, 12'd1500, 12'd3000};
    s.hi = {12'd1000, 12'd1500, 12'd3500, 12'd4095};
    load_settings(s);
    gaps_on = 1'b1;
    while (adc_timer != adc_period) send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd4095);
    send_tick(1'b0, 1'b0, 12'd4095);
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd3200);
    send_tick(1'b0, 1'b0, 12'd2000);
    send_tick(1'b0, 1'b0, 12'd1200);
    send_tick(1'b0, 1'b0, 12'd1);
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd1000);
    send_tick(1'b0, 1'b0, 12'd1001);
    send_tick(1'b0, 1'b0, 12'd3000);
    settle();
    drain();
  endtask

  // all registers but the lower bounds at their maximum, then back to short pulses
  task automatic test_extremes();
    setup_t s;
    int     goal;
    s.len_one   = '1;
    s.len_two   = '1;
    s.len_three = '1;
    s.tail_len  = '1;
    s.press_lim = '1;
    s.period    = '1;
    s.lo        = '0;
    s.hi        = '1;
    load_settings(s);
    gaps_on = 1'b1;
    goal = items_sent + 60;
    while (items_sent < goal) play_sequence();
    drain();
    s.len_one   = 16'd1;
    s.len_two   = 16'd1;
    s.len_three = 16'd1;
    s.tail_len  = 16'd100;
    s.period    = '0;
    s.lo        = '1;
    s.hi        = '0;
    load_settings(s);
    settle();
    drain();
  endtask

  // long hold with mode requests, release, then a short press
  task automatic test_long_hold();
    gaps_on = 1'b0;
    repeat (40) send_tick(1'b1, 1'($urandom_range(1)), pick_sample());
    repeat (3) send_tick(1'b0, 1'b0, pick_sample());
    settle();
    repeat (2) send_tick(1'b1, 1'b0, pick_sample());
    send_tick(1'b0, 1'b0, pick_sample());
    settle();
    drain();
  endtask

  // secondary length cut mid-pulse to a value still ahead of the timer
  task automatic test_secondary_cut();
    setup_t s;
    s = random_setup();
    s.len_one   = 16'd1;
    s.len_two   = 16'd1;
    s.len_three = 16'd1;
    s.tail_len  = 16'd40;
    s.press_lim = 16'd3;
    load_settings(s);
    gaps_on = 1'b0;
    send_tick(1'b1, 1'b0, pick_sample());
    repeat (10) send_tick(1'b0, 1'b0, pick_sample());
    drain();
    put_reg(REG_SECONDARY_TICKS, with_junk(16'd15));
    cfg_wr_en <= 1'b0;
    settle();
    repeat (4) send_tick(1'b0, 1'b0, pick_sample());
    drain();
  endtask

  initial begin
    init_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_pulses_and_modes();
    test_backpressure();
    test_random_ticks();
    test_battery_bands();
    test_extremes();
    test_long_hold();
    test_secondary_cut();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
